FILE: rtl/bxds_pkg.sv
// Shared constants and controller/datapath interface types for the box downsampler.
`timescale 1ns / 1ps
`default_nettype none

package bxds_pkg;

  // Sizing limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_FACTOR = 16;

  // Field and counter widths
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 13;
  localparam int FAC_W     = 5;
  localparam int POS_W     = 12;
  localparam int SUB_W     = 4;
  localparam int SUM_W     = 16;
  localparam int DSQ_W     = 9;
  localparam int PROD_W    = 18;
  localparam int QUO_W     = 8;
  localparam int DCNT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR       = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [FAC_W-1:0] RST_FACTOR       = 5'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take a request, latch it and start the sum read
    logic rmw;       // update the column sum and load the divider
    logic div_step;  // one quotient bit
    logic load_out;  // move the quotient into the output register
  } bxds_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic blk_done;  // request completed a whole block
    logic div_last;  // final quotient bit this cycle
    logic out_free;  // output register can take a result
  } bxds_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bxds_datapath.sv
// Datapath: configuration, position counters, column sum store, divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module bxds_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bxds_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic [bxds_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic                            in_frame_start,
  input  wire bxds_pkg::bxds_cmd_t             cmd,
  output      bxds_pkg::bxds_sts_t             sts,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [bxds_pkg::PIX_W-1:0]      out_gray,
  output      logic [bxds_pkg::POS_W-1:0]      out_x,
  output      logic [bxds_pkg::POS_W-1:0]      out_y,
  output      logic                            out_frame_done
);

  // Configuration registers
  logic [bxds_pkg::DIM_W-1:0] img_w_r, img_h_r;
  logic [bxds_pkg::FAC_W-1:0] factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= bxds_pkg::RST_IMAGE_WIDTH;
      img_h_r  <= bxds_pkg::RST_IMAGE_HEIGHT;
      factor_r <= bxds_pkg::RST_FACTOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bxds_pkg::CFG_IMAGE_WIDTH:  img_w_r  <= cfg_data;
        bxds_pkg::CFG_IMAGE_HEIGHT: img_h_r  <= cfg_data;
        bxds_pkg::CFG_FACTOR:       factor_r <= cfg_data[bxds_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate registers into their working ranges
  logic [bxds_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [bxds_pkg::FAC_W-1:0] f_eff;

  always_comb begin
    if (img_w_r == '0)
      w_eff = bxds_pkg::DIM_W'(1);
    else if (img_w_r > bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH))
      w_eff = bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH);
    else
      w_eff = img_w_r;
    if (img_h_r == '0)
      h_eff = bxds_pkg::DIM_W'(1);
    else if (img_h_r > bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH))
      h_eff = bxds_pkg::DIM_W'(bxds_pkg::MAX_WIDTH);
    else
      h_eff = img_h_r;
    if (factor_r == '0)
      f_eff = bxds_pkg::FAC_W'(1);
    else if (factor_r > bxds_pkg::FAC_W'(bxds_pkg::MAX_FACTOR))
      f_eff = bxds_pkg::FAC_W'(bxds_pkg::MAX_FACTOR);
    else
      f_eff = factor_r;
  end

  // Position counters
  logic [bxds_pkg::POS_W-1:0] col_pos_r, row_pos_r, blk_col_r, blk_row_r;
  logic [bxds_pkg::SUB_W-1:0] col_in_blk_r, row_in_blk_r;

  // Frame start clears the position before the request is used
  logic [bxds_pkg::POS_W-1:0] e_cp, e_rp, e_bc, e_br;
  logic [bxds_pkg::SUB_W-1:0] e_cib, e_rib;

  assign e_cp  = in_frame_start ? '0 : col_pos_r;
  assign e_rp  = in_frame_start ? '0 : row_pos_r;
  assign e_bc  = in_frame_start ? '0 : blk_col_r;
  assign e_br  = in_frame_start ? '0 : blk_row_r;
  assign e_cib = in_frame_start ? '0 : col_in_blk_r;
  assign e_rib = in_frame_start ? '0 : row_in_blk_r;

  // Block extent checks: block is whole if its end fits, last if the next would not
  logic [bxds_pkg::PROD_W-1:0] col_end1, col_end2, row_end1, row_end2;
  logic whole_blk, last_blk, first_px, fin_px;

  assign col_end1 = bxds_pkg::PROD_W'(e_bc) * bxds_pkg::PROD_W'(f_eff)
                  + bxds_pkg::PROD_W'(f_eff);
  assign col_end2 = col_end1 + bxds_pkg::PROD_W'(f_eff);
  assign row_end1 = bxds_pkg::PROD_W'(e_br) * bxds_pkg::PROD_W'(f_eff)
                  + bxds_pkg::PROD_W'(f_eff);
  assign row_end2 = row_end1 + bxds_pkg::PROD_W'(f_eff);

  assign whole_blk = (col_end1 <= bxds_pkg::PROD_W'(w_eff)) &&
                     (row_end1 <= bxds_pkg::PROD_W'(h_eff));
  assign last_blk  = (col_end2 > bxds_pkg::PROD_W'(w_eff)) &&
                     (row_end2 > bxds_pkg::PROD_W'(h_eff));
  assign first_px  = (e_cib == '0) && (e_rib == '0);
  assign fin_px    = ({1'b0, e_cib} == f_eff - bxds_pkg::FAC_W'(1)) &&
                     ({1'b0, e_rib} == f_eff - bxds_pkg::FAC_W'(1));

  // Advance the position
  logic [bxds_pkg::POS_W:0]   cp_inc, rp_inc;
  logic [bxds_pkg::SUB_W:0]   cib_inc, rib_inc;
  logic [bxds_pkg::POS_W-1:0] cp_nxt, rp_nxt, bc_nxt, br_nxt;
  logic [bxds_pkg::SUB_W-1:0] cib_nxt, rib_nxt;

  always_comb begin
    cp_inc  = {1'b0, e_cp} + 1'b1;
    rp_inc  = {1'b0, e_rp} + 1'b1;
    cib_inc = {1'b0, e_cib} + 1'b1;
    rib_inc = {1'b0, e_rib} + 1'b1;
    cp_nxt  = cp_inc[bxds_pkg::POS_W-1:0];
    rp_nxt  = e_rp;
    bc_nxt  = e_bc;
    br_nxt  = e_br;
    cib_nxt = cib_inc[bxds_pkg::SUB_W-1:0];
    rib_nxt = e_rib;
    if (cib_inc >= f_eff) begin
      cib_nxt = '0;
      bc_nxt  = e_bc + 1'b1;
    end
    if (cp_inc >= w_eff) begin
      cp_nxt  = '0;
      cib_nxt = '0;
      bc_nxt  = '0;
      rp_nxt  = rp_inc[bxds_pkg::POS_W-1:0];
      rib_nxt = rib_inc[bxds_pkg::SUB_W-1:0];
      if (rib_inc >= f_eff) begin
        rib_nxt = '0;
        br_nxt  = e_br + 1'b1;
      end
      if (rp_inc >= h_eff) begin
        rp_nxt  = '0;
        rib_nxt = '0;
        br_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      blk_col_r    <= '0;
      blk_row_r    <= '0;
      col_in_blk_r <= '0;
      row_in_blk_r <= '0;
    end else if (cmd.accept) begin
      col_pos_r    <= cp_nxt;
      row_pos_r    <= rp_nxt;
      blk_col_r    <= bc_nxt;
      blk_row_r    <= br_nxt;
      col_in_blk_r <= cib_nxt;
      row_in_blk_r <= rib_nxt;
    end
  end

  // Latch the request and its block flags
  logic [bxds_pkg::PIX_W-1:0] pix_r;
  logic [bxds_pkg::POS_W-1:0] addr_r, by_r;
  logic                       active_r, first_r, fin_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fin_r    <= 1'b0;
    end else if (cmd.accept) begin
      active_r <= whole_blk;
      fin_r    <= fin_px;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r   <= in_pixel;
      addr_r  <= e_bc;
      by_r    <= e_br;
      first_r <= first_px;
      last_r  <= last_blk;
    end
  end

  // Column sum store: read on accept, write back in the next cycle
  logic [bxds_pkg::SUM_W-1:0] sum_mem [bxds_pkg::MAX_WIDTH];
  logic [bxds_pkg::SUM_W-1:0] rd_data_r;
  logic [bxds_pkg::SUM_W-1:0] sum_nxt;

  assign sum_nxt = first_r ? bxds_pkg::SUM_W'(pix_r)
                           : rd_data_r + bxds_pkg::SUM_W'(pix_r);

  always_ff @(posedge clk) begin
    if (cmd.accept)
      rd_data_r <= sum_mem[e_bc];
    if (cmd.rmw && active_r)
      sum_mem[addr_r] <= sum_nxt;
  end

  // Restoring divider by factor squared, one quotient bit per cycle
  logic [bxds_pkg::SUM_W-1:0]  rem_r;
  logic [bxds_pkg::SUM_W:0]    dsh_r;
  logic [bxds_pkg::DSQ_W-1:0]  dsq_r;
  logic [bxds_pkg::QUO_W-1:0]  quo_r;
  logic [bxds_pkg::DCNT_W-1:0] cnt_r;
  logic [bxds_pkg::DSQ_W-1:0]  dsq;
  logic                        rem_ge;

  assign dsq    = bxds_pkg::DSQ_W'(f_eff * f_eff);
  assign rem_ge = {1'b0, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.rmw) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rmw) begin
      rem_r <= sum_nxt;
      dsq_r <= dsq;
      dsh_r <= {1'b0, dsq, {(bxds_pkg::QUO_W-1){1'b0}}};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge)
        rem_r <= rem_r - dsh_r[bxds_pkg::SUM_W-1:0];
      quo_r <= {quo_r[bxds_pkg::QUO_W-2:0], rem_ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  // Output register
  logic                       out_valid_r;
  logic [bxds_pkg::PIX_W-1:0] out_gray_r;
  logic [bxds_pkg::POS_W-1:0] out_x_r, out_y_r;
  logic                       out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_gray_r <= quo_r;
      out_x_r    <= addr_r;
      out_y_r    <= by_r;
      out_done_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gray       = out_gray_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_frame_done = out_done_r;

  // Status to the controller
  assign sts.blk_done = active_r && fin_r;
  assign sts.div_last = (cnt_r == bxds_pkg::DCNT_W'(bxds_pkg::QUO_W - 1));
  assign sts.out_free = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  // Finished division leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (rem_r < bxds_pkg::SUM_W'(dsq_r)))
    else $error("divider remainder not below divisor");

  // A result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

FILE: rtl/bxds_ctrl.sv
// Controller state machine: sequences request intake, sum update, division and output.
`timescale 1ns / 1ps
`default_nettype none

module bxds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire bxds_pkg::bxds_sts_t  sts,
  output      bxds_pkg::bxds_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r)
          state_nxt = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = sts.blk_done ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (sts.div_last)
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  // Commands to the datapath
  assign cmd.accept   = in_valid && in_ready_r;
  assign cmd.rmw      = (state_r == ST_RMW);
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.load_out = (state_r == ST_DONE) && sts.out_free;

  assign in_ready = in_ready_r;

`ifndef SYNTHESIS
  // Ready tracks the idle state exactly
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r == (state_r == ST_IDLE))
    else $error("ready out of step with idle state");

  // An accepted request goes straight to the sum update
  a_accept_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_RMW))
    else $error("accepted request skipped the sum update");

  // The last quotient bit ends the division
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> (state_r == ST_DONE))
    else $error("division overran");
`endif

endmodule

`default_nettype wire

FILE: rtl/box_average_downsampler_core.sv
// Top level of the box-average image downsampler.
`timescale 1ns / 1ps
`default_nettype none

// Gray pixels arrive in raster order and each whole factor-by-factor block
// is reduced to its floor mean, given with its output column, row and an
// end-of-frame mark on the last block. One request is worked at a time: a
// pixel is accepted, then a read-modify-write of the column sum store, whose
// read data is registered, updates its entry; a pixel that completes a block
// then passes the shift-subtract divider, which produces one quotient bit
// per cycle, and the hand-off into the output register. A waiting result
// does not block new requests, except that the next finished block waits
// until the previous result is taken. The sum store needs no clearing after
// reset: the first pixel of each block overwrites its entry. Registers must
// be written only while the block is idle; the block does not enforce it.
module box_average_downsampler_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bxds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bxds_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire logic [bxds_pkg::PIX_W-1:0]      in_pixel,
  input  wire logic                            in_frame_start,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [bxds_pkg::PIX_W-1:0]      out_gray,
  output      logic [bxds_pkg::POS_W-1:0]      out_x,
  output      logic [bxds_pkg::POS_W-1:0]      out_y,
  output      logic                            out_frame_done
);

  bxds_pkg::bxds_cmd_t cmd;
  bxds_pkg::bxds_sts_t sts;

  // Sequence the requests
  bxds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Counters, sum store, divider and output register
  bxds_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_gray       (out_gray),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_frame_done (out_frame_done)
  );

endmodule

`default_nettype wire
